/* design/fupd_pkg.sv */
// Shared types, codes and helper functions for the file URL percent decoder.
// No dependencies; imported by file_url_percent_decoder.
`default_nettype none

package fupd_pkg;

   // Number of bytes in the "file:///" prefix, the last of which is emitted.
   localparam int unsigned PREFIX_LEN = 8;
   localparam int unsigned POS_W      = $clog2(PREFIX_LEN);

   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   // Decoder phase.
   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_PASS   = 3'd1,
      PH_HEX1   = 3'd2,
      PH_HEX2   = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   // Status carried on the final word of a URL.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_PREFIX = 2'd1,
      ST_ESCAPE = 2'd2
   } status_type;

   // One result word.
   typedef struct packed {
      logic [7:0] path_byte;
      logic       path_valid;
      logic       end_of_path;
      status_type status;
   } result_type;

   // Expected prefix character at each position, lower case.
   function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h66; // f
         3'd1:    c = 8'h69; // i
         3'd2:    c = 8'h6c; // l
         3'd3:    c = 8'h65; // e
         3'd4:    c = 8'h3a; // :
         default: c = 8'h2f; // /
      endcase
      return c;
   endfunction

   // Map upper-case letters to lower case, leave other bytes alone.
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5a) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   // True when the byte is a hex digit of either case.
   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
   endfunction

   // Value of a hex digit; letters take the low nibble plus nine.
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] v;
      if (b <= 8'h39) begin
         v = b[3:0];
      end else begin
         v = b[3:0] + 4'h9;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* design/file_url_percent_decoder.sv */
// Top level of the file URL percent decoder: prefix check, escape decoding
// and a two-word output buffer. Depends on fupd_pkg.
//
//   Channel | Ports           | Word
//   --------+-----------------+---------------------------------------------
//   request | req_t*          | tdata: url_byte; tlast: url_last
//   result  | rsp_t*          | tdata: path_byte; tuser: path_valid, status;
//           |                 | tlast: end_of_path
//
// One byte is decoded per cycle while req_tready is high; the state update
// and the result are formed combinationally from the accepted word and land
// in the output register, or in the skid register if that one is still full.
// A skid register behind the output register lets one more byte in while a
// result waits; req_tready falls only when both hold a word.
// Reset is synchronous and active high; it clears decoder state and buffers.
`default_nettype none

module file_url_percent_decoder
   import fupd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // [7:0] url_byte
   input  wire logic       req_tlast,  // url_last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // [7:0] path_byte
   output logic [2:0]      rsp_tuser,  // [0] path_valid, [2:1] status
   output logic            rsp_tlast   // end_of_path
);

   // Decoder state.
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [3:0]         nibble_ff, nibble_in;
   status_type         err_ff, err_in;

   // Output register and skid register.
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   result_type         skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               pop;
   logic               prefix_ok;
   logic               hex_ok;
   logic [3:0]         hex_val;
   phase_type          phase_step;
   status_type         err_step;
   status_type         final_err;
   logic               emit;
   logic [7:0]         emit_byte;
   logic               push;
   result_type         result;

   assign accept    = req_tvalid && req_tready;
   assign pop       = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   // Byte classification shared by state and result logic.
   assign prefix_ok = fold_case(req_tdata) == prefix_char(pos_ff);
   assign hex_ok    = is_hex(req_tdata);
   assign hex_val   = hex_value(req_tdata);

   // Next decoder state.
   always_comb begin
      phase_step = phase_ff;
      err_step   = err_ff;
      pos_in     = pos_ff;
      nibble_in  = nibble_ff;
      case (phase_ff)
         PH_PREFIX: begin
            if (!prefix_ok) begin
               err_step   = ST_PREFIX;
               phase_step = PH_ERROR;
            end else if (pos_ff == POS_W'(PREFIX_LEN - 1)) begin
               phase_step = PH_PASS;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         PH_PASS: begin
            if (req_tdata == CHAR_PERCENT) begin
               phase_step = PH_HEX1;
            end
         end
         PH_HEX1: begin
            if (hex_ok) begin
               nibble_in  = hex_val;
               phase_step = PH_HEX2;
            end else begin
               err_step   = ST_ESCAPE;
               phase_step = PH_ERROR;
            end
         end
         PH_HEX2: begin
            if (hex_ok) begin
               phase_step = PH_PASS;
            end else begin
               err_step   = ST_ESCAPE;
               phase_step = PH_ERROR;
            end
         end
         default: begin
         end
      endcase

      // A URL that ends inside the prefix or an escape is an error.
      final_err = err_step;
      if (err_step == ST_OK) begin
         if (phase_step == PH_PREFIX) begin
            final_err = ST_PREFIX;
         end else if (phase_step == PH_HEX1 || phase_step == PH_HEX2) begin
            final_err = ST_ESCAPE;
         end
      end

      phase_in = phase_step;
      err_in   = err_step;
      if (req_tlast) begin
         phase_in  = PH_PREFIX;
         err_in    = ST_OK;
         pos_in    = '0;
         nibble_in = '0;
      end
   end

   // Result word for the accepted byte.
   always_comb begin
      emit      = 1'b0;
      emit_byte = 8'h00;
      case (phase_ff)
         PH_PREFIX: begin
            if (prefix_ok && pos_ff == POS_W'(PREFIX_LEN - 1)) begin
               emit      = 1'b1;
               emit_byte = req_tdata;
            end
         end
         PH_PASS: begin
            if (req_tdata != CHAR_PERCENT) begin
               emit      = 1'b1;
               emit_byte = req_tdata;
            end
         end
         PH_HEX2: begin
            if (hex_ok) begin
               emit      = 1'b1;
               emit_byte = {nibble_ff, hex_val};
            end
         end
         default: begin
         end
      endcase
      result.path_byte   = emit_byte;
      result.path_valid  = emit;
      result.end_of_path = req_tlast;
      result.status      = req_tlast ? final_err : ST_OK;
      push               = accept && (emit || req_tlast);
   end

   // Output register with a skid register behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         pos_ff        <= '0;
         nibble_ff     <= '0;
         err_ff        <= ST_OK;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            nibble_ff <= nibble_in;
            err_ff    <= err_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.path_byte;
   assign rsp_tuser  = {out_ff.status, out_ff.path_valid};
   assign rsp_tlast  = out_ff.end_of_path;

endmodule

`default_nettype wire

/* sim/file_url_percent_decoder_test.sv */
// Self-checking testbench for file_url_percent_decoder: random and directed URLs,
// a built-in decoder model and in-order result checking on the rsp_ stream.
// Depends on fupd_pkg and the file_url_percent_decoder RTL.
`default_nettype none

module file_url_percent_decoder_test;
   import fupd_pkg::*;

   localparam logic [63:0] PREFIX_TEXT = "file:///";
   localparam logic [7:0]  PERCENT     = 8'h25;
   localparam int          QUIET_LIMIT = 1000;
   localparam int          WORD_GOAL   = 1775;

   // One pending request word; hold makes the driver wait for all results first.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       hold;
   } url_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] url_byte
   logic       req_tlast  = 1'b0;   // url_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] path_byte
   logic [2:0] rsp_tuser;           // [0] path_valid, [2:1] status
   logic       rsp_tlast;           // end_of_path

   url_word_type url_words[$];
   logic [7:0]   url_buf[$];
   result_type   path_expect[$];

   // Decoder model state.
   phase_type  dec_phase  = PH_PREFIX;
   logic [2:0] dec_pos    = 3'd0;
   logic [3:0] dec_high   = 4'd0;
   status_type dec_status = ST_OK;

   int unsigned errors       = 0;
   int unsigned queued_words = 0;
   int unsigned urls_sent    = 0;
   int unsigned bytes_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned urls_ok      = 0;
   int unsigned urls_prefix  = 0;
   int unsigned urls_escape  = 0;
   int unsigned cycle_count  = 0;
   int unsigned quiet_cycles = 0;

   // A stretch of the run in which neither side idles.
   wire calm = (cycle_count >= 600) && (cycle_count < 1400);

   file_url_percent_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] prefix_at(input logic [2:0] pos);
      return PREFIX_TEXT[(63 - 8 * int'(pos)) -: 8];
   endfunction

   function automatic logic [7:0] fold_lower(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
   endfunction

   function automatic logic is_hex_digit(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] b);
      logic [7:0] v;
      if (b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h61) begin
         v = b - 8'h57;
      end else begin
         v = b - 8'h37;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'(8'h30 + v);
      end
      return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
   endfunction

   // Advances the decoder model by one byte and queues the result it causes.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      result_type r;
      logic       emit;
      logic [7:0] pb;
      emit = 1'b0;
      pb   = 8'h00;
      case (dec_phase)
         PH_PREFIX: begin
            if (fold_lower(b) != prefix_at(dec_pos)) begin
               dec_status = ST_PREFIX;
               dec_phase  = PH_ERROR;
            end else if (dec_pos == 3'd7) begin
               emit      = 1'b1;
               pb        = b;
               dec_phase = PH_PASS;
            end else begin
               dec_pos = dec_pos + 3'd1;
            end
         end
         PH_PASS: begin
            if (b == PERCENT) begin
               dec_phase = PH_HEX1;
            end else begin
               emit = 1'b1;
               pb   = b;
            end
         end
         PH_HEX1: begin
            if (is_hex_digit(b)) begin
               dec_high  = digit_value(b);
               dec_phase = PH_HEX2;
            end else begin
               dec_status = ST_ESCAPE;
               dec_phase  = PH_ERROR;
            end
         end
         PH_HEX2: begin
            if (is_hex_digit(b)) begin
               emit      = 1'b1;
               pb        = {dec_high, digit_value(b)};
               dec_phase = PH_PASS;
            end else begin
               dec_status = ST_ESCAPE;
               dec_phase  = PH_ERROR;
            end
         end
         default: begin
         end
      endcase

      if (last) begin
         // A URL that ends inside the prefix or inside an escape is an error too.
         if (dec_status == ST_OK) begin
            if (dec_phase == PH_PREFIX) begin
               dec_status = ST_PREFIX;
            end else if (dec_phase == PH_HEX1 || dec_phase == PH_HEX2) begin
               dec_status = ST_ESCAPE;
            end
         end
         r.path_byte   = emit ? pb : 8'h00;
         r.path_valid  = emit;
         r.end_of_path = 1'b1;
         r.status      = dec_status;
         path_expect.push_back(r);
         case (dec_status)
            ST_OK:     urls_ok++;
            ST_PREFIX: urls_prefix++;
            default:   urls_escape++;
         endcase
         dec_phase  = PH_PREFIX;
         dec_pos    = 3'd0;
         dec_high   = 4'd0;
         dec_status = ST_OK;
      end else if (emit) begin
         r.path_byte   = pb;
         r.path_valid  = 1'b1;
         r.end_of_path = 1'b0;
         r.status      = ST_OK;
         path_expect.push_back(r);
      end
   endtask

   // Moves the URL being built into the request queue, last mark on its final byte.
   task automatic send_url(input bit hold);
      url_word_type w;
      for (int i = 0; i < url_buf.size(); i++) begin
         w.data = url_buf[i];
         w.last = (i == url_buf.size() - 1);
         w.hold = hold && (i == 0);
         url_words.push_back(w);
      end
      queued_words += url_buf.size();
      urls_sent++;
      url_buf.delete();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         url_buf.push_back(s[i]);
      end
   endtask

   // Appends the first count prefix bytes with letters in random case.
   task automatic add_prefix(input int count);
      logic [7:0] c;
      for (int i = 0; i < count; i++) begin
         c = prefix_at(3'(i));
         if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1)) begin
            c = c - 8'h20;
         end
         url_buf.push_back(c);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      int         kind;
      int         k;
      logic [7:0] b;
      bit         hold;

      // Directed: mixed-case prefix ending on its slash, one-byte mismatch,
      // zero byte in the prefix, and a path with zero, 0xff, an escape and
      // an escape cut off by the last byte.
      put_text("FiLe:///");
      send_url(1'b0);
      put_text("x");
      send_url(1'b0);
      url_buf.push_back(8'h00);
      send_url(1'b0);
      put_text("file:///");
      url_buf.push_back(8'h00);
      url_buf.push_back(8'hff);
      put_text("%7E%");
      send_url(1'b0);

      hold = 1'b1;
      while (queued_words < WORD_GOAL) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            // Well-formed URL with random path bytes and escapes.
            add_prefix(8);
            repeat ($urandom_range(0, 10)) begin
               if ($urandom_range(0, 3) == 0) begin
                  url_buf.push_back(PERCENT);
                  url_buf.push_back(random_hex_digit());
                  url_buf.push_back(random_hex_digit());
               end else begin
                  do b = 8'($urandom_range(0, 255)); while (b == PERCENT);
                  url_buf.push_back(b);
               end
            end
            k = $urandom_range(0, 9);
            if (k == 0) begin
               // Bad escape in the first or second digit, then ignored bytes.
               url_buf.push_back(PERCENT);
               if ($urandom_range(0, 1)) begin
                  url_buf.push_back(random_hex_digit());
               end
               do b = 8'($urandom_range(0, 255)); while (is_hex_digit(b));
               url_buf.push_back(b);
               repeat ($urandom_range(0, 2)) url_buf.push_back(8'($urandom_range(0, 255)));
            end else if (k == 1) begin
               // Escape truncated by the end of the URL.
               url_buf.push_back(PERCENT);
               if ($urandom_range(0, 1)) begin
                  url_buf.push_back(random_hex_digit());
               end
            end
         end else if (kind < 85) begin
            // Prefix that is cut short or broken at a random position.
            k = $urandom_range(0, 7);
            add_prefix(k);
            if (k == 0 || $urandom_range(0, 1)) begin
               do b = 8'($urandom_range(0, 255));
               while (fold_lower(b) == prefix_at(3'(k)));
               url_buf.push_back(b);
               repeat ($urandom_range(0, 3)) url_buf.push_back(8'($urandom_range(0, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 6)) url_buf.push_back(8'($urandom_range(0, 255)));
         end
         send_url(hold || ($urandom_range(0, 49) == 0));
         hold = 1'b0;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (url_words.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (path_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (path_expect.size() != 0) begin
         $error("%0d expected result words never arrived", path_expect.size());
         errors++;
      end

      $display("Ran %0d URLs (%0d bytes accepted, %0d result words checked).",
               urls_sent, bytes_taken, results_seen);
      $display("Final status: %0d clean, %0d prefix errors, %0d escape errors.",
               urls_ok, urls_prefix, urls_escape);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Request driver: presents queued words, idles at random, and holds off
   // a marked word until every outstanding result has been received.
   always @(posedge clock) begin : drive
      url_word_type w;
      logic         present;
      present = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (url_words.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
            if (!url_words[0].hold || (!req_tvalid && path_expect.size() == 0)) begin
               present = 1'b1;
            end
         end
         if (present) begin
            w = url_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= w.data;
            req_tlast  <= w.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on every accepted request word and checks every
   // accepted result word against the oldest expectation.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            decode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (path_expect.size() == 0) begin
               $error("unexpected result word: tdata %02h tuser %03b tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               want = path_expect.pop_front();
               if (rsp_tdata !== want.path_byte) begin
                  $error("path_byte: expected %02h, got %02h", want.path_byte, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== want.path_valid) begin
                  $error("path_valid: expected %0b, got %0b", want.path_valid, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tlast !== want.end_of_path) begin
                  $error("end_of_path: expected %0b, got %0b", want.end_of_path, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser[2:1] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:1]);
                  errors++;
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 18);
      end
   end

   // Watchdog: ends the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
